// ===== sv/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define DBD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DBD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`else
`define DBD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define DBD_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`endif

`endif

// ===== sv/dbd_pkg.sv =====
`default_nettype none
package dbd_pkg;

  localparam int MAX_CLASSES     = 1024;
  localparam int SIGMOID_ENTRIES = 1024;
  localparam int CLS_W           = $clog2(MAX_CLASSES);
  localparam int POS_W           = $clog2(MAX_CLASSES + 5);
  localparam int SIG_IDX_W       = $clog2(SIGMOID_ENTRIES);
  localparam int IDX_MUL_W       = 33 + $clog2(SIGMOID_ENTRIES);
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONF_THRESHOLD = 4'd0,
    CFG_MODEL_WIDTH    = 4'd1,
    CFG_MODEL_HEIGHT   = 4'd2,
    CFG_PAD_X          = 4'd3,
    CFG_PAD_Y          = 4'd4,
    CFG_INVERSE_SCALE  = 4'd5,
    CFG_FRAME_WIDTH    = 4'd6,
    CFG_FRAME_HEIGHT   = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_CX   = 3'd0,
    KIND_CY   = 3'd1,
    KIND_W    = 3'd2,
    KIND_H    = 3'd3,
    KIND_CLS  = 3'd4,
    KIND_SKIP = 3'd5
  } kind_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_in_detection;
  } in_item_t;

  typedef struct packed {
    logic [12:0] box_x;
    logic [12:0] box_y;
    logic [13:0] box_w;
    logic [13:0] box_h;
    logic [15:0] score;
    logic [9:0]  class_index;
  } out_item_t;

  typedef struct packed {
    logic [15:0] conf_threshold;
    logic [12:0] model_width;
    logic [12:0] model_height;
    logic [12:0] pad_x;
    logic [12:0] pad_y;
    logic [23:0] inverse_scale;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] val;
    logic [CLS_W-1:0]   cls;
    logic               last;
    logic               enough;
  } entry_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  typedef logic [15:0] sig_table_t [SIGMOID_ENTRIES];

  // shift and subtract quotient, table build only
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [15:0] sig_entry(longint k);
    longint xk;
    longint t;
    longint u;
    longint term;
    longint sum;
    longint e;
    longint d;
    longint num;
    longint q;
    int     kk;
    xk = ((2 * k + 1) * 524288) / SIGMOID_ENTRIES - 524288;
    t = (xk < 0) ? -xk : xk;
    u = t << 10;
    sum = 64'sd1 << 30;
    term = 64'sd1 << 30;
    for (kk = 1; kk <= 12; kk++) begin
      term = longint'(udiv(longint'((term * u) >> 30), longint'(kk)));
      if ((kk % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    e = sum;
    for (kk = 0; kk < 4; kk++) e = (e * e) >> 30;
    d = (64'sd1 << 30) + e;
    num = (xk >= 0) ? (64'sd1 << 46) : (e << 16);
    q = longint'(udiv(num + (d >> 1), d));
    if (q < 1) q = 1;
    if (q > 65535) q = 65535;
    return q[15:0];
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t tbl;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) tbl[k] = sig_entry(longint'(k));
    return tbl;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

// ===== sv/dbd_front.sv =====
`default_nettype none
module dbd_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  dbd_pkg::in_item_t   in_data_i,
  input  dbd_pkg::fifo_stat_t fifo_stat_i,
  output logic                push_o,
  output dbd_pkg::entry_t     entry_o
);
  import dbd_pkg::*;

  logic [POS_W-1:0]     position_q, position_d;
  logic [32:0]          t_w;
  logic [IDX_MUL_W-1:0] scaled;
  logic [IDX_MUL_W-1:0] shifted;
  logic [SIG_IDX_W-1:0] idx;

  assign in_stall_o = fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

  // table index of a logit
  always_comb begin
    t_w     = {in_data_i.value[31], in_data_i.value} + 33'd524288;
    scaled  = IDX_MUL_W'(t_w[31:0]) * IDX_MUL_W'(SIGMOID_ENTRIES);
    shifted = scaled >> 20;
    if (t_w[32]) begin
      idx = '0;
    end else if (shifted > IDX_MUL_W'(SIGMOID_ENTRIES - 1)) begin
      idx = SIG_IDX_W'(SIGMOID_ENTRIES - 1);
    end else begin
      idx = shifted[SIG_IDX_W-1:0];
    end
  end

  always_comb begin
    entry_o.val    = in_data_i.value;
    entry_o.cls    = CLS_W'(position_q - POS_W'(4));
    entry_o.last   = in_data_i.last_in_detection;
    entry_o.enough = position_q >= POS_W'(5);
    if (position_q == POS_W'(0)) begin
      entry_o.kind = KIND_CX;
    end else if (position_q == POS_W'(1)) begin
      entry_o.kind = KIND_CY;
    end else if (position_q == POS_W'(2)) begin
      entry_o.kind = KIND_W;
    end else if (position_q == POS_W'(3)) begin
      entry_o.kind = KIND_H;
    end else if (position_q >= POS_W'(4 + MAX_CLASSES)) begin
      entry_o.kind = KIND_SKIP;
    end else begin
      entry_o.kind = KIND_CLS;
      entry_o.val  = 32'(idx);
    end
  end

  always_comb begin
    position_d = position_q;
    if (push_o) begin
      if (in_data_i.last_in_detection) begin
        position_d = '0;
      end else if (position_q < POS_W'(4 + MAX_CLASSES)) begin
        position_d = position_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
    end else begin
      position_q <= position_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dbd_fifo.sv =====
`default_nettype none
module dbd_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  dbd_pkg::entry_t     entry_i,
  input  wire                 pop_i,
  output dbd_pkg::entry_t     head_o,
  output dbd_pkg::fifo_stat_t stat_o
);
  import dbd_pkg::*;

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = count_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign stat_o.empty = count_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/dbd_back.sv =====
`default_nettype none
module dbd_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  dbd_pkg::cfg_t       cfg_i,
  input  dbd_pkg::entry_t     head_i,
  input  dbd_pkg::fifo_stat_t fifo_stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output dbd_pkg::out_item_t  out_data_o
);
  import dbd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCALE = 7'b0000010,
    ST_OFFS  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_CLO   = 7'b0010000,
    ST_CSZ   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e st_q, st_d;

  logic               a_valid_q;
  entry_t             a_entry_q;
  logic [15:0]        rom_q;
  logic               advance;

  logic [15:0]        best_q;
  logic [CLS_W-1:0]   bcls_q;
  logic [15:0]        nbest;
  logic [CLS_W-1:0]   ncls;
  logic               emit;
  logic               norm;

  logic signed [31:0] cx_q, cy_q, w_q, h_q;
  logic [15:0]        res_score_q;
  logic [CLS_W-1:0]   res_cls_q;

  logic signed [45:0] xc_q, xs_q, yc_q, ys_q;
  logic signed [47:0] op_q [4];
  logic signed [72:0] r_q [4];
  logic [46:0]        org_q [2];
  logic [46:0]        size_q [2];
  logic [47:0]        lo_q;
  logic [2:0]         sub_q;
  logic [1:0]         j_q;
  logic [1:0]         ph_q;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod_q;
  logic [72:0]        r_sum;

  logic [13:0]        fx, fy;
  logic [46:0]        fmx_x, fmx_y;
  logic [46:0]        lim_x, lim_y;
  logic [47:0]        rnd_x, rnd_y, rnd_w, rnd_h;

  out_item_t          out_q;
  logic               free_slot;

  function automatic logic [13:0] frame_fix(logic [13:0] f);
    if (f == 14'd0) return 14'd1;
    if (f > 14'd8192) return 14'd8192;
    return f;
  endfunction

  function automatic logic [46:0] clamp_hi(logic signed [72:0] v, logic [46:0] hi);
    if (v[72]) return '0;
    if (v[71:0] > {25'b0, hi}) return hi;
    return v[46:0];
  endfunction

  assign advance   = a_valid_q && (st_q == ST_IDLE);
  assign pop_o     = !fifo_stat_i.empty && (!a_valid_q || advance);
  assign free_slot = !out_valid_o || !out_stall_i;

  always_comb begin
    nbest = best_q;
    ncls  = bcls_q;
    if (a_entry_q.kind == KIND_CLS && rom_q > best_q) begin
      nbest = rom_q;
      ncls  = a_entry_q.cls;
    end
  end

  assign emit = a_entry_q.last && a_entry_q.enough && (nbest != 16'd0) &&
                (nbest >= cfg_i.conf_threshold);
  assign norm = (cx_q <= 32'sd98304) && (cy_q <= 32'sd98304) &&
                (w_q <= 32'sd98304) && (h_q <= 32'sd98304);

  assign fx    = frame_fix(cfg_i.frame_width);
  assign fy    = frame_fix(cfg_i.frame_height);
  assign fmx_x = {14'(fx - 14'd1), 33'b0};
  assign fmx_y = {14'(fy - 14'd1), 33'b0};
  assign lim_x = {fx, 33'b0} - org_q[0];
  assign lim_y = {fy, 33'b0} - org_q[1];
  assign r_sum = ({{15{prod_q[57]}}, prod_q} << 24) + {25'b0, lo_q};

  assign rnd_x = {1'b0, org_q[0]} + 48'h1_0000_0000;
  assign rnd_y = {1'b0, org_q[1]} + 48'h1_0000_0000;
  assign rnd_w = {1'b0, size_q[0]} + 48'h1_0000_0000;
  assign rnd_h = {1'b0, size_q[1]} + 48'h1_0000_0000;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      ST_SCALE: begin
        case (sub_q)
          3'd0: begin
            mul_a = xc_q[32:0];
            mul_b = {12'b0, cfg_i.model_width};
          end
          3'd1: begin
            mul_a = xs_q[32:0];
            mul_b = {12'b0, cfg_i.model_width};
          end
          3'd2: begin
            mul_a = yc_q[32:0];
            mul_b = {12'b0, cfg_i.model_height};
          end
          3'd3: begin
            mul_a = ys_q[32:0];
            mul_b = {12'b0, cfg_i.model_height};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_MUL: begin
        mul_b = {1'b0, cfg_i.inverse_scale};
        if (ph_q == 2'd0) begin
          mul_a = {9'b0, op_q[j_q][23:0]};
        end else begin
          mul_a = {{9{op_q[j_q][47]}}, op_q[j_q][47:24]};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (advance && emit) st_d = norm ? ST_SCALE : ST_OFFS;
      ST_SCALE: if (sub_q == 3'd4) st_d = ST_OFFS;
      ST_OFFS:  st_d = ST_MUL;
      ST_MUL:   if (ph_q == 2'd2 && j_q == 2'd3) st_d = ST_CLO;
      ST_CLO:   st_d = ST_CSZ;
      ST_CSZ:   st_d = ST_OUT;
      ST_OUT:   if (free_slot) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      a_valid_q   <= 1'b0;
      best_q      <= '0;
      bcls_q      <= '0;
      sub_q       <= '0;
      j_q         <= '0;
      ph_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (pop_o) begin
        a_valid_q <= 1'b1;
      end else if (advance) begin
        a_valid_q <= 1'b0;
      end
      if (advance) begin
        if (a_entry_q.last) begin
          best_q <= '0;
          bcls_q <= '0;
        end else begin
          best_q <= nbest;
          bcls_q <= ncls;
        end
      end
      if (st_q == ST_SCALE) begin
        sub_q <= sub_q + 3'd1;
      end else begin
        sub_q <= '0;
      end
      if (st_q == ST_MUL) begin
        if (ph_q == 2'd2) begin
          ph_q <= '0;
          j_q  <= j_q + 2'd1;
        end else begin
          ph_q <= ph_q + 2'd1;
        end
      end else begin
        ph_q <= '0;
        j_q  <= '0;
      end
      if (st_q == ST_OUT && free_slot) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (pop_o) begin
      a_entry_q <= head_i;
      rom_q     <= SIG_TABLE[head_i.val[SIG_IDX_W-1:0]];
    end
    if (advance) begin
      case (a_entry_q.kind)
        KIND_CX: cx_q <= a_entry_q.val;
        KIND_CY: cy_q <= a_entry_q.val;
        KIND_W:  w_q <= a_entry_q.val;
        KIND_H:  h_q <= a_entry_q.val;
        default: begin
        end
      endcase
      if (emit) begin
        res_score_q <= nbest;
        res_cls_q   <= ncls;
        xc_q        <= 46'(cx_q);
        yc_q        <= 46'(cy_q);
        xs_q        <= w_q[31] ? '0 : 46'(w_q);
        ys_q        <= h_q[31] ? '0 : 46'(h_q);
      end
    end
    case (st_q)
      ST_SCALE: begin
        case (sub_q)
          3'd1: xc_q <= prod_q[45:0];
          3'd2: xs_q <= prod_q[45:0];
          3'd3: yc_q <= prod_q[45:0];
          3'd4: ys_q <= prod_q[45:0];
          default: begin
          end
        endcase
      end
      ST_OFFS: begin
        op_q[0] <= (48'(xc_q) <<< 1) - 48'(xs_q) - (48'(cfg_i.pad_x) << 17);
        op_q[1] <= 48'(xs_q) <<< 1;
        op_q[2] <= (48'(yc_q) <<< 1) - 48'(ys_q) - (48'(cfg_i.pad_y) << 17);
        op_q[3] <= 48'(ys_q) <<< 1;
      end
      ST_MUL: begin
        if (ph_q == 2'd1) lo_q <= prod_q[47:0];
        if (ph_q == 2'd2) r_q[j_q] <= r_sum;
      end
      ST_CLO: begin
        org_q[0] <= clamp_hi(r_q[0], fmx_x);
        org_q[1] <= clamp_hi(r_q[2], fmx_y);
      end
      ST_CSZ: begin
        size_q[0] <= clamp_hi(r_q[1], lim_x);
        size_q[1] <= clamp_hi(r_q[3], lim_y);
      end
      ST_OUT: begin
        if (free_slot) begin
          out_q.box_x       <= rnd_x[45:33];
          out_q.box_y       <= rnd_y[45:33];
          out_q.box_w       <= rnd_w[46:33];
          out_q.box_h       <= rnd_h[46:33];
          out_q.score       <= res_score_q;
          out_q.class_index <= 10'(res_cls_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ===== sv/detection_box_decode_filter.sv =====
`default_nettype none
// Detection output decoder. Values stream in one per transaction (cx, cy, w, h, then
// class logits, last flag on the final value) and enter a 4-entry queue at up to one
// per cycle unless it is full. While idle and fed, the back end scores one class logit per cycle
// through a registered sigmoid ROM and keeps the first maximum. When a detection of at
// least six values passes the threshold, the box math runs on one shared 33x25 multiplier
// (scaling by the model size when the box is normalized, then offset, multiply, origin and
// size clamps, output), plus any wait for the output register; the queue keeps taking input meanwhile until it fills.
`include "assert_macros.svh"
module detection_box_decode_filter (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  dbd_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output dbd_pkg::out_item_t          out_data_o,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [dbd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire [23:0]                  cfg_data_i
);
  import dbd_pkg::*;

  cfg_t       cfg_q;
  fifo_stat_t fifo_stat;
  entry_t     push_entry;
  entry_t     head;
  logic       push;
  logic       pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_threshold <= 16'd16384;
      cfg_q.model_width    <= 13'd640;
      cfg_q.model_height   <= 13'd640;
      cfg_q.pad_x          <= '0;
      cfg_q.pad_y          <= '0;
      cfg_q.inverse_scale  <= 24'd65536;
      cfg_q.frame_width    <= 14'd1920;
      cfg_q.frame_height   <= 14'd1080;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CONF_THRESHOLD: cfg_q.conf_threshold <= cfg_data_i[15:0];
        CFG_MODEL_WIDTH:    cfg_q.model_width    <= cfg_data_i[12:0];
        CFG_MODEL_HEIGHT:   cfg_q.model_height   <= cfg_data_i[12:0];
        CFG_PAD_X:          cfg_q.pad_x          <= cfg_data_i[12:0];
        CFG_PAD_Y:          cfg_q.pad_y          <= cfg_data_i[12:0];
        CFG_INVERSE_SCALE:  cfg_q.inverse_scale  <= cfg_data_i;
        CFG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i[13:0];
        CFG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i[13:0];
        default: begin
        end
      endcase
    end
  end

  dbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  dbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .stat_o  (fifo_stat)
  );

  dbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `DBD_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
  `DBD_ASSERT_IMPLY(a_pop_nonempty, clk_i, rst_ni, pop, !fifo_stat.empty)
  `DBD_ASSERT_IMPLY(a_push_room, clk_i, rst_ni, push, fifo_stat.count < FIFO_CNT_W'(FIFO_DEPTH))

endmodule
`default_nettype wire
